>>> rtl/clbr_pkg.sv
// Shared types, codes and constants for the character LCD refresh unit.
package clbr_pkg;

   localparam int DEF_COLUMNS = 20;
   localparam int DEF_ROWS    = 4;

   // Input operation codes
   localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
   localparam logic [1:0] OP_SET_CURSOR = 2'd1;
   localparam logic [1:0] OP_REFRESH    = 2'd2;
   localparam logic [1:0] OP_TICK       = 2'd3;

   // Refresh sequencer phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_LOCATE = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
   localparam logic [7:0] SPACE_CHAR     = 8'h20;

   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic [4:0] col;
      logic [2:0] row;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       last;
   } rsp_type;

   // One byte handed to the nibble serializer
   typedef struct packed {
      logic       load;
      logic       rs;
      logic [7:0] data;
   } byte_load_type;

   function automatic logic [7:0] row_offset(input logic [1:0] r);
      logic [7:0] ofs;
      unique case (r)
         2'd0:    ofs = 8'h00;
         2'd1:    ofs = 8'h40;
         2'd2:    ofs = 8'h14;
         default: ofs = 8'h54;
      endcase
      return ofs;
   endfunction

endpackage

>>> rtl/clbr_char_mem.sv
// Character store: synchronous memory with per-entry valid bits, reads space until written.
module clbr_char_mem
   import clbr_pkg::*;
#(
   parameter int CELLS = DEF_COLUMNS * DEF_ROWS,
   parameter int IDX_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0]       mem [CELLS];
   logic [CELLS-1:0] written_ff;
   logic [7:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Unwritten entries read back as a space
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem[rd_addr] : SPACE_CHAR;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/clbr_nibble_out.sv
// Output register: splits one byte into high and low nibble items on the result channel.
module clbr_nibble_out
   import clbr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  byte_load_type load,
   output logic          busy,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   logic       valid_ff, valid_in;
   logic       low_ff, low_in;
   logic       rs_ff;
   logic [7:0] byte_ff;

   always_comb begin
      valid_in = valid_ff;
      low_in   = low_ff;
      if (load.load) begin
         valid_in = 1'b1;
         low_in   = 1'b0;
      end else if (valid_ff && !rsp_stall) begin
         if (low_ff) begin
            valid_in = 1'b0;
         end else begin
            low_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         low_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         rs_ff   <= load.rs;
         byte_ff <= load.data;
      end
   end

   // Free when empty, or once the low nibble leaves this cycle
   assign busy      = valid_ff && !(low_ff && !rsp_stall);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.reg_select = rs_ff;
      rsp_data.nibble     = low_ff ? byte_ff[3:0] : byte_ff[7:4];
      rsp_data.last       = low_ff;
   end

endmodule

>>> rtl/char_lcd_buffered_refresh_unit.sv
// Top level: command decode, write cursor and refresh sequencer around the character store.
//
// Usage: items on req_ carry an op (write character, set cursor, request
// refresh, tick). Writes land in the character store at the cursor; a set
// cursor outside COLUMNS x ROWS is dropped. A refresh request is latched and
// started by a later tick; each further tick sends at most one set-address
// byte or one character byte to the display.
// Every byte leaves on rsp_ as two items: the high nibble (last low), then the
// low nibble (last high), with reg_select low for instructions, high for data.
// The first nibble comes from the output register after the tick is taken; a
// character tick first reads the store (a registered read) and loads the byte
// into the output register when the data returns. Items that emit nothing do
// not raise req_stall. The next item is taken in the cycle the low nibble
// leaves.
// Reset clears the cursor and sequencer and marks every store entry unwritten,
// so it reads as a space; no clearing pass is needed. While rsp_stall is high
// the current nibble holds and req_stall stays high until the byte is out.
module char_lcd_buffered_refresh_unit
   import clbr_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic             pending_ff, pending_in;
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [COL_W-1:0] rcol_ff, rcol_in;
   logic [1:0]       rrow_ff, rrow_in;
   logic             read_busy_ff, read_busy_in;

   logic             accept;
   logic             out_busy;
   logic             mem_we, mem_re;
   logic [7:0]       mem_rd;
   logic             cursor_ok;
   byte_load_type    load;

   assign req_stall = read_busy_ff || out_busy;
   assign accept    = req_valid && !req_stall;
   assign mem_we    = accept && (req_data.op == OP_WRITE_CHAR);

   assign cursor_ok = ({1'b0, req_data.col} < 6'(COLUMNS)) &&
                      ({1'b0, req_data.row} < 4'(ROWS));

   always_comb begin
      cursor_in    = cursor_ff;
      pending_in   = pending_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      rcol_in      = rcol_ff;
      rrow_in      = rrow_ff;
      read_busy_in = 1'b0;
      mem_re       = 1'b0;
      load.load    = 1'b0;
      load.rs      = RS_INSTR;
      load.data    = SET_DDRAM_ADDR;

      // Character read returns: hand it to the output register
      if (read_busy_ff) begin
         load.load = 1'b1;
         load.rs   = RS_DATA;
         load.data = mem_rd;
      end

      if (accept) begin
         case (req_data.op)
            OP_WRITE_CHAR: begin
               cursor_in = (cursor_ff == IDX_W'(CELLS - 1)) ? '0 : cursor_ff + 1'b1;
            end
            OP_SET_CURSOR: begin
               if (cursor_ok) begin
                  cursor_in = IDX_W'(32'(req_data.row) * COLUMNS + 32'(req_data.col));
               end
            end
            OP_REFRESH: begin
               pending_in = 1'b1;
            end
            default: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        phase_in   = PH_START;
                     end
                  end
                  PH_START: begin
                     index_in  = '0;
                     rcol_in   = '0;
                     rrow_in   = '0;
                     load.load = 1'b1;
                     load.rs   = RS_INSTR;
                     load.data = SET_DDRAM_ADDR + row_offset(2'd0);
                     phase_in  = PH_LOCATE;
                  end
                  PH_LOCATE: begin
                     if (rcol_ff == '0) begin
                        load.load = 1'b1;
                        load.rs   = RS_INSTR;
                        load.data = SET_DDRAM_ADDR + row_offset(rrow_ff);
                     end
                     phase_in = PH_DATA;
                  end
                  default: begin
                     mem_re       = 1'b1;
                     read_busy_in = 1'b1;
                     if (rcol_ff == COL_W'(COLUMNS - 1)) begin
                        rcol_in = '0;
                        rrow_in = rrow_ff + 1'b1;
                     end else begin
                        rcol_in = rcol_ff + 1'b1;
                     end
                     if (index_ff == IDX_W'(CELLS - 1)) begin
                        index_in = '0;
                        phase_in = PH_IDLE;
                     end else begin
                        index_in = index_ff + 1'b1;
                        phase_in = PH_LOCATE;
                     end
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         pending_ff   <= 1'b0;
         phase_ff     <= PH_IDLE;
         index_ff     <= '0;
         rcol_ff      <= '0;
         rrow_ff      <= '0;
         read_busy_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         pending_ff   <= pending_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         rcol_ff      <= rcol_in;
         rrow_ff      <= rrow_in;
         read_busy_ff <= read_busy_in;
      end
   end

   clbr_char_mem #(
      .CELLS (CELLS),
      .IDX_W (IDX_W)
   ) u_char_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (cursor_ff),
      .wr_data (req_data.char_code),
      .rd_en   (mem_re),
      .rd_addr (index_ff),
      .rd_data (mem_rd)
   );

   clbr_nibble_out u_nibble_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .busy      (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
